FILE: hw/rtl/lras_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared codes and fixed widths of the line rasterizer.
// ----------------------------------------------------------------------------
package lras_pkg;

    localparam int ADDR_W  = 32;
    localparam int PITCH_W = 16;
    localparam int CFG_W   = 32;

    typedef logic [1:0] t_cfg_idx;
    typedef logic [1:0] t_step;
    typedef logic       t_kind;

    // configuration register indexes
    localparam t_cfg_idx CFG_FRAME_BASE = 2'd0;
    localparam t_cfg_idx CFG_ROW_PITCH  = 2'd1;
    localparam t_cfg_idx CFG_PEN_COLOR  = 2'd2;

    localparam logic [PITCH_W-1:0] ROW_PITCH_RESET = 16'd2560;

    // command kinds
    localparam t_kind KIND_START   = 1'b0;
    localparam t_kind KIND_ADVANCE = 1'b1;

    // step direction codes
    localparam t_step STEP_NONE  = 2'd0;
    localparam t_step STEP_PLUS  = 2'd1;
    localparam t_step STEP_MINUS = 2'd3;

endpackage
`default_nettype wire

FILE: hw/rtl/lras_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer command channel
// Valid/ready channel carrying start and advance commands.
// ----------------------------------------------------------------------------
interface lras_in_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lras_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer pixel channel
// Valid/ready channel carrying one pixel write per beat.
// ----------------------------------------------------------------------------
interface lras_out_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [31:0]           pixel_address;
    logic [31:0]           pixel_value;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_value, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_value, last_pixel,
                    output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lras_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer step stage
// Input register, line state and one Bresenham step per advance beat.
// ----------------------------------------------------------------------------
module lras_step #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    lras_in_if.sink                            i_cmd,
    input  wire logic [lras_pkg::ADDR_W-1:0]   i_frame_base,
    input  wire logic [lras_pkg::PITCH_W-1:0]  i_row_pitch,
    output logic                               o_pre_valid,
    input  wire logic                          i_pre_ready,
    output logic [COORD_BITS-1:0]              o_pre_col,
    output logic [COORD_BITS-1:0]              o_pre_row,
    output logic [lras_pkg::ADDR_W-1:0]        o_pre_row_addr,
    output logic                               o_pre_last
);
    localparam int DW = COORD_BITS + 1;   // signed delta
    localparam int TW = COORD_BITS + 2;   // doubled delta
    localparam int EW = COORD_BITS + 4;   // error term
    localparam int PW = COORD_BITS + lras_pkg::PITCH_W;

    function automatic logic [COORD_BITS-1:0] f_step(
        input logic [COORD_BITS-1:0] c,
        input lras_pkg::t_step       code
    );
        logic [COORD_BITS-1:0] res;
        case (code)
            lras_pkg::STEP_PLUS:  res = c + COORD_BITS'(1);
            lras_pkg::STEP_MINUS: res = c - COORD_BITS'(1);
            default:              res = c;
        endcase
        return res;
    endfunction

    function automatic lras_pkg::t_step f_code(input logic signed [DW-1:0] d);
        lras_pkg::t_step res;
        if (d == '0) begin
            res = lras_pkg::STEP_NONE;
        end else if (d[DW-1]) begin
            res = lras_pkg::STEP_MINUS;
        end else begin
            res = lras_pkg::STEP_PLUS;
        end
        return res;
    endfunction

    // input register
    logic                  r_in_valid;
    lras_pkg::t_kind       r_in_kind;
    logic [COORD_BITS-1:0] r_in_sx, r_in_sy, r_in_ex, r_in_ey;

    // line state
    logic                  r_line_active;
    logic [COORD_BITS-1:0] r_col, r_row, r_goal_col, r_goal_row;
    logic [EW-1:0]         r_err;
    logic [TW-1:0]         r_tdx, r_tdy;
    lras_pkg::t_step       r_step_col, r_step_row;
    logic                  r_x_major;
    logic [31:0]           r_row_addr;

    // result register
    logic                  r_pre_valid;
    logic [COORD_BITS-1:0] r_pre_col, r_pre_row;
    logic [31:0]           r_pre_row_addr;
    logic                  r_pre_last;

    logic                  w_go, w_start, w_emit, w_last;

    // start setup
    logic signed [DW-1:0]  s_dx, s_dy, s_adx, s_ady;
    logic [TW-1:0]         s_tdx, s_tdy;
    logic                  s_xmaj, s_last;
    logic [EW-1:0]         s_err;
    logic [PW-1:0]         s_prod;
    logic [31:0]           s_row_addr;

    // advance step
    logic                  a_ege, a_row_mv, a_col_mv, a_last;
    logic [COORD_BITS-1:0] a_col, a_row;
    logic [EW-1:0]         a_err, a_sub, a_add;
    logic [31:0]           a_row_addr;

    assign w_go        = r_in_valid && (!r_pre_valid || i_pre_ready);
    assign w_start     = (r_in_kind == lras_pkg::KIND_START);
    assign w_emit      = w_start || r_line_active;
    assign w_last      = w_start ? s_last : a_last;
    assign i_cmd.ready = !r_in_valid || w_go;

    always_comb begin
        s_dx   = $signed({1'b0, r_in_ex}) - $signed({1'b0, r_in_sx});
        s_dy   = $signed({1'b0, r_in_ey}) - $signed({1'b0, r_in_sy});
        s_adx  = s_dx[DW-1] ? -s_dx : s_dx;
        s_ady  = s_dy[DW-1] ? -s_dy : s_dy;
        s_tdx  = {1'b0, s_adx[COORD_BITS-1:0], 1'b0};
        s_tdy  = {1'b0, s_ady[COORD_BITS-1:0], 1'b0};
        s_xmaj = s_tdx > s_tdy;
        if (s_xmaj) begin
            s_err = EW'(s_tdy) - EW'(s_tdx[TW-1:1]);
        end else begin
            s_err = EW'(s_tdx) - EW'(s_tdy[TW-1:1]);
        end
        s_prod     = PW'(r_in_sy) * PW'(i_row_pitch);
        s_row_addr = i_frame_base + 32'(s_prod);
        s_last     = s_xmaj ? (r_in_sx == r_in_ex) : (r_in_sy == r_in_ey);
    end

    always_comb begin
        a_ege    = !r_err[EW-1];
        a_row_mv = !r_x_major || a_ege;
        a_col_mv = r_x_major || a_ege;
        a_col    = a_col_mv ? f_step(r_col, r_step_col) : r_col;
        a_row    = a_row_mv ? f_step(r_row, r_step_row) : r_row;
        a_sub    = r_x_major ? EW'(r_tdx) : EW'(r_tdy);
        a_add    = r_x_major ? EW'(r_tdy) : EW'(r_tdx);
        a_err    = r_err - (a_ege ? a_sub : '0) + a_add;
        a_row_addr = r_row_addr;
        if (a_row_mv) begin
            case (r_step_row)
                lras_pkg::STEP_PLUS:  a_row_addr = r_row_addr + 32'(i_row_pitch);
                lras_pkg::STEP_MINUS: a_row_addr = r_row_addr - 32'(i_row_pitch);
                default:              a_row_addr = r_row_addr;
            endcase
        end
        a_last = r_x_major ? (a_col == r_goal_col) : (a_row == r_goal_row);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_pre_valid   <= 1'b0;
            r_line_active <= 1'b0;
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (w_go) begin
                r_pre_valid <= w_emit;
            end else if (i_pre_ready) begin
                r_pre_valid <= 1'b0;
            end
            if (w_go && w_emit) begin
                r_line_active <= !w_last;
            end
        end
    end

    // payload and line datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_kind <= i_cmd.kind;
            r_in_sx   <= i_cmd.start_x;
            r_in_sy   <= i_cmd.start_y;
            r_in_ex   <= i_cmd.end_x;
            r_in_ey   <= i_cmd.end_y;
        end
        if (w_go && w_start) begin
            r_col      <= r_in_sx;
            r_row      <= r_in_sy;
            r_goal_col <= r_in_ex;
            r_goal_row <= r_in_ey;
            r_tdx      <= s_tdx;
            r_tdy      <= s_tdy;
            r_step_col <= f_code(s_dx);
            r_step_row <= f_code(s_dy);
            r_x_major  <= s_xmaj;
            r_err      <= s_err;
            r_row_addr <= s_row_addr;
        end else if (w_go && r_line_active) begin
            r_col      <= a_col;
            r_row      <= a_row;
            r_err      <= a_err;
            r_row_addr <= a_row_addr;
        end
        if (w_go && w_emit) begin
            r_pre_col      <= w_start ? r_in_sx : a_col;
            r_pre_row      <= w_start ? r_in_sy : a_row;
            r_pre_row_addr <= w_start ? s_row_addr : a_row_addr;
            r_pre_last     <= w_last;
        end
    end

    assign o_pre_valid    = r_pre_valid;
    assign o_pre_col      = r_pre_col;
    assign o_pre_row      = r_pre_row;
    assign o_pre_row_addr = r_pre_row_addr;
    assign o_pre_last     = r_pre_last;

`ifndef SYNTHESIS
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_emit && w_last) |=> !r_line_active)
        else $error("line still active after its endpoint pixel");

    a_idle_advance_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (r_in_kind == lras_pkg::KIND_ADVANCE) && !r_line_active) |=> !r_pre_valid)
        else $error("advance without an active line produced a pixel");

    a_xmajor_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line_active && r_x_major) |-> (r_tdx != '0))
        else $error("x-major line with zero x delta");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/lras_addr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer address stage
// Adds the column offset to the row start and holds the pixel beat.
// ----------------------------------------------------------------------------
module lras_addr #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_pre_valid,
    output logic                             o_pre_ready,
    input  wire logic [COORD_BITS-1:0]       i_pre_col,
    input  wire logic [COORD_BITS-1:0]       i_pre_row,
    input  wire logic [lras_pkg::ADDR_W-1:0] i_pre_row_addr,
    input  wire logic                        i_pre_last,
    input  wire logic [lras_pkg::CFG_W-1:0]  i_pen_color,
    lras_out_if.source                       o_pix
);
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [31:0]           r_out_addr;
    logic                  r_out_last;

    assign o_pre_ready = !r_out_valid || o_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pre_ready) begin
            r_out_valid <= i_pre_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pre_valid && o_pre_ready) begin
            r_out_x    <= i_pre_col;
            r_out_y    <= i_pre_row;
            r_out_addr <= i_pre_row_addr + 32'({i_pre_col, 2'b00});
            r_out_last <= i_pre_last;
        end
    end

    assign o_pix.valid         = r_out_valid;
    assign o_pix.pixel_x       = r_out_x;
    assign o_pix.pixel_y       = r_out_y;
    assign o_pix.pixel_address = r_out_addr;
    assign o_pix.pixel_value   = i_pen_color;
    assign o_pix.last_pixel    = r_out_last;

endmodule
`default_nettype wire

FILE: hw/rtl/line_rasterizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer unit
// Bresenham line walker producing 32-bit frame buffer pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries commands. kind START loads both endpoints and emits the
//   first pixel; kind ADVANCE emits the next pixel of the active line and is
//   dropped without a beat when no line is active. A START during a line
//   abandons the old line.
//   o_pix carries one pixel per beat: x, y, byte address
//   (frame_base + y * row_pitch + 4 * x, modulo 2^32), pen color and a flag
//   on the endpoint pixel, which also ends the line.
//   Configuration: write frame_base, row_pitch, pen_color through
//   i_cfg_we/i_cfg_index/i_cfg_data while no command is in flight.
//   Timing: one command per cycle sustained while o_pix is not stalled; a
//   pixel passes the input register, step register and address register
//   after its command beat. The step loop (error update, row address +/-
//   pitch) closes within the step register, which sets the rate.
//   Reset: no line active, frame_base 0, row_pitch 2560, pen_color 0.
//   Stall: a stalled o_pix holds its beat; the two stages behind it keep
//   filling, then i_cmd.ready drops until the pixel is taken.
// ----------------------------------------------------------------------------
module line_rasterizer_unit #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    lras_in_if.sink                           i_cmd,
    lras_out_if.source                        o_pix,
    input  wire logic                         i_cfg_we,
    input  wire lras_pkg::t_cfg_idx           i_cfg_index,
    input  wire logic [lras_pkg::CFG_W-1:0]   i_cfg_data
);
    // configuration registers
    logic [lras_pkg::ADDR_W-1:0]  r_frame_base;
    logic [lras_pkg::PITCH_W-1:0] r_row_pitch;
    logic [lras_pkg::CFG_W-1:0]   r_pen_color;

    // step stage to address stage
    logic                         w_pre_valid;
    logic                         w_pre_ready;
    logic [COORD_BITS-1:0]        w_pre_col;
    logic [COORD_BITS-1:0]        w_pre_row;
    logic [lras_pkg::ADDR_W-1:0]  w_pre_row_addr;
    logic                         w_pre_last;

    // Take register writes; an index past the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= '0;
            r_row_pitch  <= lras_pkg::ROW_PITCH_RESET;
            r_pen_color  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lras_pkg::CFG_FRAME_BASE: r_frame_base <= i_cfg_data;
                lras_pkg::CFG_ROW_PITCH:  r_row_pitch  <= i_cfg_data[lras_pkg::PITCH_W-1:0];
                lras_pkg::CFG_PEN_COLOR:  r_pen_color  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Walk the line: set up on START, one Bresenham step per ADVANCE.
    lras_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .i_frame_base   (r_frame_base),
        .i_row_pitch    (r_row_pitch),
        .o_pre_valid    (w_pre_valid),
        .i_pre_ready    (w_pre_ready),
        .o_pre_col      (w_pre_col),
        .o_pre_row      (w_pre_row),
        .o_pre_row_addr (w_pre_row_addr),
        .o_pre_last     (w_pre_last)
    );

    // Add the column offset and hold the pixel beat for the writer.
    lras_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pre_valid    (w_pre_valid),
        .o_pre_ready    (w_pre_ready),
        .i_pre_col      (w_pre_col),
        .i_pre_row      (w_pre_row),
        .i_pre_row_addr (w_pre_row_addr),
        .i_pre_last     (w_pre_last),
        .i_pen_color    (r_pen_color),
        .o_pix          (o_pix)
    );

endmodule
`default_nettype wire

FILE: test/line_rasterizer_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer unit testbench
// Sends start and advance commands with random gaps and stalls the pixel
// channel at random. A Bresenham walker, updated on every accepted command,
// predicts each pixel beat, and the beat is checked field by field.
// ----------------------------------------------------------------------------
module line_rasterizer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lras_pkg::*;

    localparam int COORD_BITS    = 12;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int SETTLE_CYCLES = 8;     // lets commands that produce no pixel drain
    localparam int REPORT_LIMIT  = 10;

    // index with no register behind it; writes to it must change nothing
    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord              x;
        t_coord              y;
        logic [ADDR_W-1:0]   addr;
        logic [31:0]         value;
        logic                last;
    } t_pixel;

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    t_cfg_idx         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    lras_in_if  #(.COORD_BITS(COORD_BITS)) cmd_if ();
    lras_out_if #(.COORD_BITS(COORD_BITS)) pix_if ();

    line_rasterizer_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_if),
        .o_pix       (pix_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Walker state: a private copy of the registers and of the line in flight
    // ------------------------------------------------------------------------
    logic [31:0]       cfg_base  = '0;
    logic [PITCH_W-1:0] cfg_pitch = ROW_PITCH_RESET;
    logic [31:0]       cfg_color = '0;

    bit                line_on   = 1'b0;
    t_coord            walk_col  = '0;
    t_coord            walk_row  = '0;
    t_coord            goal_col  = '0;
    t_coord            goal_row  = '0;
    int                err       = 0;
    int                twice_dx  = 0;
    int                twice_dy  = 0;
    t_step             col_step  = STEP_NONE;
    t_step             row_step  = STEP_NONE;
    bit                x_major   = 1'b0;
    logic [ADDR_W-1:0] row_addr  = '0;

    t_pixel pending_pixels [$];     // predicted beats not yet seen on o_pix
    int     lit_count      = 0;     // commands that produced a pixel
    int     mismatch_count = 0;
    int     src_idle_pct   = 0;     // chance of a gap after each command beat
    int     snk_stall_pct  = 0;     // chance of a stall on each ready cycle
    int     stall_left     = 0;

    // Mostly no gap; when there is one it is short, now and then long.
    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_step step_of(int delta);
        if (delta > 0) return STEP_PLUS;
        if (delta < 0) return STEP_MINUS;
        return STEP_NONE;
    endfunction

    // Coordinates wrap at the coordinate width.
    function automatic t_coord step_coord(t_coord c, t_step s);
        case (s)
            STEP_PLUS:  return c + 1'b1;
            STEP_MINUS: return c - 1'b1;
            default:    return c;
        endcase
    endfunction

    // Move one row and keep the row start address in step with it.
    function automatic void move_row();
        walk_row = step_coord(walk_row, row_step);
        if (row_step == STEP_PLUS) begin
            row_addr = row_addr + cfg_pitch;
        end else if (row_step == STEP_MINUS) begin
            row_addr = row_addr - cfg_pitch;
        end
    endfunction

    // Apply one command to the walker; return 1 with the pixel it emits.
    function automatic bit walk_pixel(input t_kind kind, input t_coord sx, sy, ex, ey,
                                      output t_pixel px);
        int dx;
        int dy;
        bit at_end;
        if (kind == KIND_START) begin
            walk_col = sx;
            walk_row = sy;
            goal_col = ex;
            goal_row = ey;
            dx       = int'(ex) - int'(sx);
            dy       = int'(ey) - int'(sy);
            twice_dx = (dx < 0 ? -dx : dx) * 2;
            twice_dy = (dy < 0 ? -dy : dy) * 2;
            col_step = step_of(dx);
            row_step = step_of(dy);
            // equal deltas walk along y
            x_major  = twice_dx > twice_dy;
            err      = x_major ? twice_dy - twice_dx / 2 : twice_dx - twice_dy / 2;
            row_addr = cfg_base + ADDR_W'(walk_row) * ADDR_W'(cfg_pitch);
        end else begin
            if (!line_on) return 1'b0;
            if (x_major) begin
                if (err >= 0) begin
                    move_row();
                    err -= twice_dx;
                end
                walk_col = step_coord(walk_col, col_step);
                err += twice_dy;
            end else begin
                if (err >= 0) begin
                    walk_col = step_coord(walk_col, col_step);
                    err -= twice_dy;
                end
                move_row();
                err += twice_dx;
            end
        end
        at_end   = x_major ? (walk_col == goal_col) : (walk_row == goal_row);
        line_on  = !at_end;
        px.x     = walk_col;
        px.y     = walk_row;
        px.addr  = row_addr + (ADDR_W'(walk_col) << 2);
        px.value = cfg_color;
        px.last  = at_end;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Hold the beat until it is taken, predict it, then maybe idle. Valid
    // stays high into the next call when no gap is drawn.
    task automatic issue_cmd(input t_kind kind, input t_coord sx, sy, ex, ey);
        t_pixel px;
        int     gap;
        cmd_if.valid   <= 1'b1;
        cmd_if.kind    <= kind;
        cmd_if.start_x <= sx;
        cmd_if.start_y <= sy;
        cmd_if.end_x   <= ex;
        cmd_if.end_y   <= ey;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        if (walk_pixel(kind, sx, sy, ex, ey, px)) begin
            pending_pixels.push_back(px);
            lit_count++;
        end
        gap = pick_gap(src_idle_pct);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Endpoint fields are ignored on advance; fill them with noise anyway.
    task automatic issue_advance();
        issue_cmd(KIND_ADVANCE, t_coord'($urandom), t_coord'($urandom),
                  t_coord'($urandom), t_coord'($urandom));
    endtask

    // Drop valid, drain every predicted pixel, then let the pipeline empty
    // of commands that produce nothing.
    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all registers back to back while idle, plus one write to the
    // unused index with junk data.
    task automatic load_config(input logic [31:0] base, input logic [PITCH_W-1:0] pitch,
                               input logic [31:0] color);
        t_cfg_idx         idx [4];
        logic [CFG_W-1:0] val [4];
        settle();
        idx = '{CFG_FRAME_BASE, CFG_ROW_PITCH, CFG_UNUSED, CFG_PEN_COLOR};
        // upper bits of the pitch write are junk and must be dropped
        val = '{base, {16'($urandom), pitch}, CFG_W'($urandom), color};
        foreach (idx[i]) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge i_clk);
        end
        cfg_we    <= 1'b0;
        cfg_base  = base;
        cfg_pitch = pitch;
        cfg_color = color;
    endtask

    // Pick an endpoint within span of s, flipping direction at the edges.
    function automatic t_coord near_coord(int s, int span);
        int e;
        int d;
        d = $urandom_range(span);
        e = $urandom_range(1) ? s + d : s - d;
        if (e > COORD_MAX || e < 0) e = 2 * s - e;
        return t_coord'(e);
    endfunction

    // Mostly whole short lines walked to their end; some long far-apart
    // lines cut off by a new start; some advances with nothing to walk.
    task automatic run_random_lines(int count);
        int     target;
        int     roll;
        int     span;
        t_coord sx;
        t_coord sy;
        target = lit_count + count;
        while (lit_count < target) begin
            roll = $urandom_range(99);
            if (roll < 75) begin
                span = ($urandom_range(9) == 0) ? 300 : 24;
                sx   = t_coord'($urandom);
                sy   = t_coord'($urandom);
                issue_cmd(KIND_START, sx, sy, near_coord(int'(sx), span),
                          near_coord(int'(sy), span));
                while (line_on && lit_count < target) issue_advance();
                if ($urandom_range(9) == 0) issue_advance();
            end else if (roll < 90) begin
                issue_cmd(KIND_START, t_coord'($urandom), t_coord'($urandom),
                          t_coord'($urandom), t_coord'($urandom));
                repeat ($urandom_range(6)) begin
                    if (line_on) issue_advance();
                end
            end else begin
                repeat ($urandom_range(1, 2)) issue_advance();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Pixel side: random stalls and the beat checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = pick_gap(snk_stall_pct);
        end else begin
            stall_left--;
        end
        pix_if.ready <= (stall_left == 0);
    end

    always @(posedge i_clk) begin
        t_pixel want;
        t_pixel got;
        if (i_rst_n === 1'b1 && pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
            got = '{pix_if.pixel_x, pix_if.pixel_y, pix_if.pixel_address,
                    pix_if.pixel_value, pix_if.last_pixel};
            if (pending_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("%t: unexpected pixel x=%0d y=%0d addr=%h value=%h last=%b",
                             $realtime, got.x, got.y, got.addr, got.value, got.last);
                end
            end else begin
                want = pending_pixels.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.addr !== want.addr ||
                    got.value !== want.value || got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%t: pixel mismatch", $realtime);
                        $display("    expected x=%0d y=%0d addr=%h value=%h last=%b",
                                 want.x, want.y, want.addr, want.value, want.last);
                        $display("    actual   x=%0d y=%0d addr=%h value=%h last=%b",
                                 got.x, got.y, got.addr, got.value, got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Advance with no line gives nothing; then a single point under the
    // reset values of the registers.
    task automatic test_idle_advance();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        issue_advance();
        issue_advance();
        issue_cmd(KIND_START, 12'd10, 12'd20, 12'd10, 12'd20);
    endtask

    // Extreme endpoints, both dominant axes, ties, both step signs, a start
    // that cuts a line short, and advances past the end of a line.
    task automatic test_directed_lines();
        src_idle_pct  = 30;
        snk_stall_pct = 30;
        // address wraps past the top of the address space
        load_config(32'hFFFF_FFF0, 16'hFFFF, 32'hFFFF_FFFF);
        issue_cmd(KIND_START, 12'd0, 12'd0, 12'd0, 12'd0);
        issue_advance();
        // x dominant, both steps negative, from the far corner
        issue_cmd(KIND_START, 12'hFFF, 12'hFFF, 12'hFFC, 12'hFFE);
        while (line_on) issue_advance();
        issue_advance();
        // equal deltas: y dominant
        issue_cmd(KIND_START, 12'd0, 12'hFFF, 12'd2, 12'hFFD);
        while (line_on) issue_advance();
        // long diagonal, abandoned after three pixels by a vertical line
        issue_cmd(KIND_START, 12'hFFF, 12'd0, 12'd0, 12'hFFF);
        issue_advance();
        issue_advance();
        issue_cmd(KIND_START, 12'd5, 12'd5, 12'd5, 12'd7);
        while (line_on) issue_advance();
        // horizontal
        issue_cmd(KIND_START, 12'd7, 12'd3, 12'd9, 12'd3);
        while (line_on) issue_advance();
    endtask

    // Register extremes, each followed by a burst of lines.
    task automatic test_config_extremes();
        src_idle_pct  = 20;
        snk_stall_pct = 20;
        load_config(32'h0000_0000, 16'h0000, 32'h0000_0000);
        run_random_lines(40);
        load_config(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        run_random_lines(40);
        load_config(32'h0000_0000, ROW_PITCH_RESET, 32'hA5A5_5A5A);
        run_random_lines(40);
        load_config(32'h8000_0000, 16'h0001, 32'h5A5A_A5A5);
        run_random_lines(40);
    endtask

    // Bulk traffic: random registers per phase; the first phase runs with
    // no gaps and no stalls, the others with a random amount of each.
    task automatic test_random_lines();
        for (int phase = 0; phase < 5; phase++) begin
            src_idle_pct  = (phase == 0) ? 0 : $urandom_range(10, 60);
            snk_stall_pct = (phase == 0) ? 0 : $urandom_range(10, 60);
            load_config($urandom, PITCH_W'($urandom), $urandom);
            run_random_lines(140);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        cmd_if.valid   <= 1'b0;
        cmd_if.kind    <= KIND_START;
        cmd_if.start_x <= '0;
        cmd_if.start_y <= '0;
        cmd_if.end_x   <= '0;
        cmd_if.end_y   <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_FRAME_BASE;
        cfg_data       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_advance();
        test_directed_lines();
        test_config_extremes();
        test_random_lines();
        settle();

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Hang guard: far beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

FILE: line_rasterizer_unit.f
hw/rtl/lras_pkg.sv
hw/rtl/lras_in_if.sv
hw/rtl/lras_out_if.sv
hw/rtl/lras_step.sv
hw/rtl/lras_addr.sv
hw/rtl/line_rasterizer_unit.sv
test/line_rasterizer_unit_tb.sv
